// ----- src/bsd_pkg.sv -----
// ----------------------------------------------------------------------------
// bsd_pkg: shared constants, types and helpers of the byte split delta filter
// Sizes, configuration register codes and the size clamping functions.
// ----------------------------------------------------------------------------
package bsd_pkg;

	// Block limits
	localparam int MAX_CHANNELS = 64;
	localparam int MAX_ELEMS    = 262144;

	// Counter and field widths
	localparam int CH_W       = $clog2(MAX_CHANNELS);
	localparam int IDX_W      = $clog2(MAX_ELEMS);
	localparam int CCNT_W     = 7;
	localparam int ECNT_W     = 19;
	localparam int BYTE_W     = 8;
	localparam int ADDR_W     = 24;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 19;
	localparam int PROD_W     = ECNT_W + CCNT_W;

	typedef logic [BYTE_W-1:0] byte_t;
	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [CH_W-1:0]   ch_t;
	typedef logic [IDX_W-1:0]  idx_t;
	typedef logic [CCNT_W-1:0] ccnt_t;
	typedef logic [ECNT_W-1:0] ecnt_t;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CHANNEL_COUNT     = 2'd0,
		CFG_ELEMS_PER_CHANNEL = 2'd1,
		CFG_DECODE_MODE       = 2'd2,
		CFG_DELTA_ENABLE      = 2'd3
	} cfg_reg_t;

	// Item in flight between the accept stage and the output register
	typedef struct packed {
		byte_t               data;
		byte_t               dec_res;
		logic                hist_vld;
		logic                delta;
		logic                mode;
		logic                last;
		logic [PROD_W-1:0]   prod;
		idx_t                addend;
	} stage_t;

	// Zero acts as one, oversize saturates
	function automatic ccnt_t eff_channels(input ccnt_t c);
		ccnt_t r;
		r = c;
		if (c == '0)
			r = ccnt_t'(1);
		else if (c > ccnt_t'(MAX_CHANNELS))
			r = ccnt_t'(MAX_CHANNELS);
		return r;
	endfunction

	function automatic ecnt_t eff_elems(input ecnt_t e);
		ecnt_t r;
		r = e;
		if (e == '0)
			r = ecnt_t'(1);
		else if (e > ecnt_t'(MAX_ELEMS))
			r = ecnt_t'(MAX_ELEMS);
		return r;
	endfunction

endpackage

// ----- src/bsd_ifs.sv -----
// ----------------------------------------------------------------------------
// bsd_ifs: channel interfaces of the byte split delta filter
// Source items, result items and the configuration write channel.
// ----------------------------------------------------------------------------
interface bsd_in_if;
	logic           valid;
	logic           ready;
	bsd_pkg::byte_t data_byte;
	logic           block_start;

	modport source (output valid, output data_byte, output block_start, input ready);
	modport sink   (input valid, input data_byte, input block_start, output ready);
endinterface

interface bsd_out_if;
	logic           valid;
	logic           ready;
	bsd_pkg::addr_t out_address;
	bsd_pkg::byte_t out_byte;
	logic           block_last;

	modport source (output valid, output out_address, output out_byte, output block_last,
		input ready);
	modport sink   (input valid, input out_address, input out_byte, input block_last,
		output ready);
endinterface

interface bsd_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [bsd_pkg::CFG_IDX_W-1:0]     reg_index;
	logic [bsd_pkg::CFG_DATA_W-1:0]    wdata;

	modport source (output valid, output reg_index, output wdata, input ready);
	modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

// ----- src/byte_split_channel_delta_filter.sv -----
// ----------------------------------------------------------------------------
// byte_split_channel_delta_filter: byte shuffle filter with per-channel delta
// Encode turns interleaved records into split order with per-channel deltas;
// decode rebuilds interleaved bytes from split order with a running sum.
//
//   port  | dir | carries
//   ------+-----+------------------------------------------------
//   src   | in  | data_byte, block_start
//   dst   | out | out_address, out_byte, block_last
//   cfg   | in  | reg_index, wdata (always ready)
//
// One item per cycle unless dst stalls; items pass stage 1, then out register.
// Channel history sits in a 64 x 8 RAM read and written at the accept edge,
// so consecutive bytes of one channel need no forwarding.
// Reset clears counters, accumulator and the history valid bits; no sweep.
// A stalled output holds one result and one more item in the pipe.
// ----------------------------------------------------------------------------
module byte_split_channel_delta_filter (
	input  logic        clk,
	input  logic        arst_n,
	bsd_in_if.sink      src,
	bsd_out_if.source   dst,
	bsd_cfg_if.sink     cfg
);

	// Configuration registers
	bsd_pkg::ccnt_t channel_count_q;
	bsd_pkg::ecnt_t elems_per_channel_q;
	logic           decode_mode_q;
	logic           delta_enable_q;

	// Block position and decode sum
	bsd_pkg::ch_t   ch_q;
	bsd_pkg::idx_t  idx_q;
	bsd_pkg::byte_t acc_q;
	logic [bsd_pkg::MAX_CHANNELS-1:0] hvld_q;

	// History RAM
	bsd_pkg::byte_t hist_mem [bsd_pkg::MAX_CHANNELS];
	bsd_pkg::byte_t hist_rd_s1;

	// Pipeline
	bsd_pkg::stage_t st_s1;
	logic            vld_s1;
	logic            out_vld_q;
	bsd_pkg::addr_t  out_addr_q;
	bsd_pkg::byte_t  out_byte_q;
	logic            out_last_q;

	// Accept stage signals
	logic            in_acc;
	logic            s1_move;
	bsd_pkg::ccnt_t  c_eff;
	bsd_pkg::ecnt_t  e_eff;
	bsd_pkg::ch_t    ch_cur;
	bsd_pkg::idx_t   idx_cur;
	bsd_pkg::byte_t  acc_cur;
	logic            ch_end;
	logic            idx_end;
	logic            last_cur;
	bsd_pkg::ch_t    ch_nxt;
	bsd_pkg::idx_t   idx_nxt;
	bsd_pkg::byte_t  dec_res;
	bsd_pkg::byte_t  acc_nxt;
	logic [bsd_pkg::MAX_CHANNELS-1:0] hvld_base;
	logic [bsd_pkg::MAX_CHANNELS-1:0] hvld_nxt;
	bsd_pkg::ecnt_t  mul_a;
	bsd_pkg::ccnt_t  mul_b;
	logic [bsd_pkg::PROD_W-1:0] prod;
	bsd_pkg::byte_t  hist_val;
	bsd_pkg::byte_t  res_s1;
	bsd_pkg::addr_t  addr_s1;

	// Handshakes
	assign cfg.ready = 1'b1;
	assign s1_move   = vld_s1 && (!out_vld_q || dst.ready);
	assign src.ready = !vld_s1 || s1_move;
	assign in_acc    = src.valid && src.ready;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			channel_count_q     <= bsd_pkg::ccnt_t'(1);
			elems_per_channel_q <= bsd_pkg::ecnt_t'(1);
			decode_mode_q       <= 1'b0;
			delta_enable_q      <= 1'b1;
		end else if (cfg.valid && cfg.ready) begin
			case (bsd_pkg::cfg_reg_t'(cfg.reg_index))
				bsd_pkg::CFG_CHANNEL_COUNT:
					channel_count_q <= cfg.wdata[bsd_pkg::CCNT_W-1:0];
				bsd_pkg::CFG_ELEMS_PER_CHANNEL:
					elems_per_channel_q <= cfg.wdata[bsd_pkg::ECNT_W-1:0];
				bsd_pkg::CFG_DECODE_MODE:
					decode_mode_q <= cfg.wdata[0];
				bsd_pkg::CFG_DELTA_ENABLE:
					delta_enable_q <= cfg.wdata[0];
				default: ;
			endcase
		end
	end

	// Position, end flags and next position
	always_comb begin
		c_eff   = bsd_pkg::eff_channels(channel_count_q);
		e_eff   = bsd_pkg::eff_elems(elems_per_channel_q);
		ch_cur  = src.block_start ? '0 : ch_q;
		idx_cur = src.block_start ? '0 : idx_q;
		acc_cur = src.block_start ? '0 : acc_q;
		ch_end  = (bsd_pkg::ccnt_t'({1'b0, ch_cur}) + bsd_pkg::ccnt_t'(1)) >= c_eff;
		idx_end = (bsd_pkg::ecnt_t'({1'b0, idx_cur}) + bsd_pkg::ecnt_t'(1)) >= e_eff;
		last_cur = ch_end && idx_end;

		ch_nxt  = ch_cur;
		idx_nxt = idx_cur;
		if (last_cur) begin
			ch_nxt  = '0;
			idx_nxt = '0;
		end else if (!decode_mode_q) begin
			if (ch_end) begin
				ch_nxt  = '0;
				idx_nxt = idx_cur + bsd_pkg::idx_t'(1);
			end else begin
				ch_nxt = ch_cur + bsd_pkg::ch_t'(1);
			end
		end else begin
			if (idx_end) begin
				idx_nxt = '0;
				ch_nxt  = ch_cur + bsd_pkg::ch_t'(1);
			end else begin
				idx_nxt = idx_cur + bsd_pkg::idx_t'(1);
			end
		end

		// Decode running sum; restarts at each channel and block
		dec_res = delta_enable_q ? src.data_byte + acc_cur : src.data_byte;
		if (last_cur || (decode_mode_q && idx_end))
			acc_nxt = '0;
		else if (decode_mode_q)
			acc_nxt = dec_res;
		else
			acc_nxt = acc_cur;

		// History valid bits: an entry not written this block reads as zero
		hvld_base = src.block_start ? '0 : hvld_q;
		hvld_nxt  = hvld_base;
		if (!decode_mode_q)
			hvld_nxt[ch_cur] = 1'b1;
		if (last_cur)
			hvld_nxt = '0;

		// Address product: split order ch*e, interleaved idx*c
		mul_a = decode_mode_q ? bsd_pkg::ecnt_t'({1'b0, idx_cur}) : e_eff;
		mul_b = decode_mode_q ? c_eff : bsd_pkg::ccnt_t'({1'b0, ch_cur});
		prod  = bsd_pkg::PROD_W'(mul_a) * bsd_pkg::PROD_W'(mul_b);
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ch_q   <= '0;
			idx_q  <= '0;
			acc_q  <= '0;
			hvld_q <= '0;
		end else if (in_acc) begin
			ch_q   <= ch_nxt;
			idx_q  <= idx_nxt;
			acc_q  <= acc_nxt;
			hvld_q <= hvld_nxt;
		end
	end

	// History RAM: read old value; in encode, write new byte at the same edge
	always_ff @(posedge clk) begin
		if (in_acc) begin
			hist_rd_s1 <= hist_mem[ch_cur];
			if (!decode_mode_q)
				hist_mem[ch_cur] <= src.data_byte;
		end
	end

	// Stage 1 register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else if (src.ready)
			vld_s1 <= src.valid;
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			st_s1.data     <= src.data_byte;
			st_s1.dec_res  <= dec_res;
			st_s1.hist_vld <= hvld_base[ch_cur];
			st_s1.delta    <= delta_enable_q;
			st_s1.mode     <= decode_mode_q;
			st_s1.last     <= last_cur;
			st_s1.prod     <= prod;
			st_s1.addend   <= decode_mode_q ? bsd_pkg::idx_t'(ch_cur) : idx_cur;
		end
	end

	// Stage 1: encode delta or decode result, and final address
	always_comb begin
		hist_val = st_s1.hist_vld ? hist_rd_s1 : '0;
		if (st_s1.mode)
			res_s1 = st_s1.dec_res;
		else if (st_s1.delta)
			res_s1 = st_s1.data - hist_val;
		else
			res_s1 = st_s1.data;
		addr_s1 = st_s1.prod[bsd_pkg::ADDR_W-1:0]
			+ bsd_pkg::addr_t'(st_s1.addend);
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_vld_q <= 1'b0;
		else if (s1_move)
			out_vld_q <= 1'b1;
		else if (dst.ready)
			out_vld_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			out_addr_q <= addr_s1;
			out_byte_q <= res_s1;
			out_last_q <= st_s1.last;
		end
	end

	assign dst.valid       = out_vld_q;
	assign dst.out_address = out_addr_q;
	assign dst.out_byte    = out_byte_q;
	assign dst.block_last  = out_last_q;

`ifndef SYNTHESIS
	// Block end clears position, sum and history
	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && last_cur |=> ch_q == '0 && idx_q == '0 && acc_q == '0 && hvld_q == '0)
		else $error("state not cleared after block end");

	// Decode sum restarts at channel end
	a_acc_restart: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && decode_mode_q && idx_end |=> acc_q == '0)
		else $error("decode sum not restarted");

	// Input only stalls when both pipeline slots are full and blocked
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!src.ready |-> vld_s1 && out_vld_q && !dst.ready)
		else $error("input stalled with room in pipeline");

	// A blocked result holds the item behind it
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && !s1_move |=> vld_s1 && $stable(st_s1))
		else $error("stage 1 item lost under stall");
`endif

endmodule

// ----- dv/tb_byte_split_channel_delta_filter.sv -----
// ----------------------------------------------------------------------------
// tb_byte_split_channel_delta_filter: self-checking bench of the byte split filter
// Sends interleaved and split-order bytes under many channel and element
// settings, predicts the filtered byte, its destination offset and the block
// end flag for every item taken, and checks each result against the oldest
// prediction. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_byte_split_channel_delta_filter;

	localparam int unsigned RANDOM_ITEMS = 1200;
	localparam int unsigned QUIET_WAIT   = 4;
	localparam int unsigned CYCLE_LIMIT  = 300000;

	typedef enum {OP_ITEM, OP_CFG, OP_PAUSE} op_kind_t;

	typedef struct {
		op_kind_t                        kind;
		bsd_pkg::byte_t                  data;
		logic                            first;
		bsd_pkg::cfg_reg_t               reg_sel;
		logic [bsd_pkg::CFG_DATA_W-1:0]  wdata;
	} pend_op_t;

	typedef struct packed {
		bsd_pkg::addr_t addr;
		bsd_pkg::byte_t val;
		logic           last;
	} result_t;

	logic clk = 1'b0;
	logic arst_n;

	bsd_in_if  src_if ();
	bsd_out_if dst_if ();
	bsd_cfg_if cfg_if ();

	byte_split_channel_delta_filter u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.src    (src_if),
		.dst    (dst_if),
		.cfg    (cfg_if)
	);

	// Work for the driver and results still owed by the block
	pend_op_t stream_ops[$];
	result_t  due_out[$];

	// Shadow copy of the filter state and settings
	bsd_pkg::byte_t chan_hist [bsd_pkg::MAX_CHANNELS];
	bsd_pkg::byte_t run_sum;
	int unsigned    chan_pos;
	int unsigned    elem_pos;
	bsd_pkg::ccnt_t chan_cfg;
	bsd_pkg::ecnt_t elem_cfg;
	logic           dec_mode;
	logic           delta_on;

	// Pacing and bookkeeping
	int unsigned gap_left     = 0;
	int unsigned src_burst    = 0;
	int unsigned stall_left   = 0;
	int unsigned dst_burst    = 0;
	int unsigned quiet_cycles = 0;
	int unsigned cycle_count  = 0;
	int unsigned items_queued = 0;
	int unsigned items_taken  = 0;
	int unsigned results_seen = 0;
	int unsigned blocks_ended = 0;
	int unsigned reg_writes   = 0;
	int unsigned drain_pauses = 0;
	int unsigned mismatches   = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Clear counters, history and running sum: block start and block end
	function automatic void clear_history();
		foreach (chan_hist[i])
			chan_hist[i] = '0;
		run_sum  = '0;
		chan_pos = 0;
		elem_pos = 0;
	endfunction

	// Filter one byte under the current settings and queue its result
	function automatic void shuffle_step(input bsd_pkg::byte_t v, input logic first);
		int unsigned     c;
		int unsigned     e;
		int unsigned     ch;
		int unsigned     idx;
		longint unsigned a;
		logic            ch_end;
		logic            idx_end;
		logic            last;
		bsd_pkg::byte_t  res;
		result_t         r;
		c = (chan_cfg == 0) ? 1 : ((chan_cfg > bsd_pkg::MAX_CHANNELS) ?
			bsd_pkg::MAX_CHANNELS : chan_cfg);
		e = (elem_cfg == 0) ? 1 : ((elem_cfg > bsd_pkg::MAX_ELEMS) ?
			bsd_pkg::MAX_ELEMS : elem_cfg);
		if (first)
			clear_history();
		ch  = chan_pos;
		idx = elem_pos;
		if (ch >= bsd_pkg::MAX_CHANNELS)
			ch = bsd_pkg::MAX_CHANNELS - 1;
		if (dec_mode)
			a = longint'(idx) * c + ch;
		else
			a = longint'(ch) * e + idx;
		ch_end  = (ch + 1 >= c);
		idx_end = (idx + 1 >= e);
		last    = ch_end && idx_end;

		if (!dec_mode) begin
			// encode: delta against the previous byte of this channel
			res = delta_on ? bsd_pkg::byte_t'(v - chan_hist[ch]) : v;
			chan_hist[ch] = v;
			if (ch_end) begin
				ch  = 0;
				idx = idx_end ? 0 : idx + 1;
			end else begin
				ch++;
			end
		end else begin
			// decode: running sum that restarts with every channel
			res = delta_on ? bsd_pkg::byte_t'(v + run_sum) : v;
			run_sum = res;
			if (idx_end) begin
				idx     = 0;
				ch      = ch_end ? 0 : ch + 1;
				run_sum = '0;
			end else begin
				idx++;
			end
		end

		if (last) begin
			clear_history();
		end else begin
			chan_pos = ch;
			elem_pos = idx;
		end
		r.addr = bsd_pkg::addr_t'(a);
		r.val  = res;
		r.last = last;
		due_out.push_back(r);
	endfunction

	// Wait before the next item: none within a burst, else drawn at random
	function automatic int unsigned draw_wait(inout int unsigned burst);
		if (burst > 0) begin
			burst--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0) begin
			burst = $urandom_range(20, 60);
			return 0;
		end
		return $urandom_range(0, 4);
	endfunction

	function automatic void flag_mismatch(input string field, input int unsigned want,
		input int unsigned got);
		mismatches++;
		$display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, want, got);
	endfunction

	function automatic void push_item(input bsd_pkg::byte_t v, input logic first);
		pend_op_t op;
		op.kind    = OP_ITEM;
		op.data    = v;
		op.first   = first;
		op.reg_sel = bsd_pkg::CFG_CHANNEL_COUNT;
		op.wdata   = '0;
		stream_ops.push_back(op);
		items_queued++;
	endfunction

	function automatic void push_pause();
		pend_op_t op;
		op.kind    = OP_PAUSE;
		op.data    = '0;
		op.first   = 1'b0;
		op.reg_sel = bsd_pkg::CFG_CHANNEL_COUNT;
		op.wdata   = '0;
		stream_ops.push_back(op);
	endfunction

	// All four registers, written once the block has gone idle
	function automatic void push_settings(input int unsigned c, input int unsigned e,
		input logic dec, input logic dlt);
		pend_op_t op;
		op.kind  = OP_CFG;
		op.data  = '0;
		op.first = 1'b0;
		op.reg_sel = bsd_pkg::CFG_CHANNEL_COUNT;
		op.wdata   = bsd_pkg::CFG_DATA_W'(c);
		stream_ops.push_back(op);
		op.reg_sel = bsd_pkg::CFG_ELEMS_PER_CHANNEL;
		op.wdata   = bsd_pkg::CFG_DATA_W'(e);
		stream_ops.push_back(op);
		op.reg_sel = bsd_pkg::CFG_DECODE_MODE;
		op.wdata   = bsd_pkg::CFG_DATA_W'(dec);
		stream_ops.push_back(op);
		op.reg_sel = bsd_pkg::CFG_DELTA_ENABLE;
		op.wdata   = bsd_pkg::CFG_DATA_W'(dlt);
		stream_ops.push_back(op);
	endfunction

	// Source and configuration driver
	always @(posedge clk) begin
		logic     in_vld_nxt;
		logic     cfg_vld_nxt;
		pend_op_t op;
		if (arst_n) begin
			in_vld_nxt  = src_if.valid;
			cfg_vld_nxt = cfg_if.valid;

			// item taken: work out its result
			if (src_if.valid && src_if.ready) begin
				shuffle_step(src_if.data_byte, src_if.block_start);
				items_taken++;
				in_vld_nxt = 1'b0;
			end

			// register write taken: follow it in the shadow settings
			if (cfg_if.valid && cfg_if.ready) begin
				case (bsd_pkg::cfg_reg_t'(cfg_if.reg_index))
					bsd_pkg::CFG_CHANNEL_COUNT:
						chan_cfg = cfg_if.wdata[bsd_pkg::CCNT_W-1:0];
					bsd_pkg::CFG_ELEMS_PER_CHANNEL:
						elem_cfg = cfg_if.wdata[bsd_pkg::ECNT_W-1:0];
					bsd_pkg::CFG_DECODE_MODE:
						dec_mode = cfg_if.wdata[0];
					bsd_pkg::CFG_DELTA_ENABLE:
						delta_on = cfg_if.wdata[0];
					default: ;
				endcase
				reg_writes++;
				cfg_vld_nxt = 1'b0;
			end

			// idle once nothing is owed and no item is offered
			if (due_out.size() == 0 && !src_if.valid)
				quiet_cycles++;
			else
				quiet_cycles = 0;

			if (!in_vld_nxt && !cfg_vld_nxt && stream_ops.size() > 0) begin
				op = stream_ops[0];
				case (op.kind)
					OP_ITEM: begin
						if (gap_left > 0) begin
							gap_left--;
						end else begin
							src_if.data_byte   <= op.data;
							src_if.block_start <= op.first;
							in_vld_nxt = 1'b1;
							void'(stream_ops.pop_front());
							gap_left = draw_wait(src_burst);
						end
					end
					OP_CFG: begin
						if (quiet_cycles >= QUIET_WAIT) begin
							cfg_if.reg_index <= op.reg_sel;
							cfg_if.wdata     <= op.wdata;
							cfg_vld_nxt = 1'b1;
							void'(stream_ops.pop_front());
						end
					end
					OP_PAUSE: begin
						if (quiet_cycles >= QUIET_WAIT) begin
							void'(stream_ops.pop_front());
							drain_pauses++;
						end
					end
					default: ;
				endcase
			end

			src_if.valid <= in_vld_nxt;
			cfg_if.valid <= cfg_vld_nxt;
		end
	end

	// Result monitor with random back-pressure
	always @(posedge clk) begin
		result_t want;
		if (arst_n) begin
			if (dst_if.valid && dst_if.ready) begin
				results_seen++;
				if (dst_if.block_last)
					blocks_ended++;
				if (due_out.size() == 0) begin
					mismatches++;
					$display("%0t: result with none expected, got address 0x%0h byte 0x%0h",
						$time, dst_if.out_address, dst_if.out_byte);
				end else begin
					want = due_out.pop_front();
					if (dst_if.out_address !== want.addr)
						flag_mismatch("out_address", 32'(want.addr),
							32'(dst_if.out_address));
					if (dst_if.out_byte !== want.val)
						flag_mismatch("out_byte", 32'(want.val), 32'(dst_if.out_byte));
					if (dst_if.block_last !== want.last)
						flag_mismatch("block_last", 32'(want.last),
							32'(dst_if.block_last));
				end
				stall_left = draw_wait(dst_burst);
			end else if (dst_if.valid && stall_left > 0) begin
				stall_left--;
			end
			dst_if.ready <= (stall_left == 0);
		end
	end

	// Run time guard
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("%0t: run still busy after %0d cycles", $time, CYCLE_LIMIT);
			$display("byte_split_channel_delta_filter test failed");
			$finish;
		end
	end

	initial begin
		int unsigned c_raw;
		int unsigned e_raw;
		int unsigned c_eff;
		int unsigned e_eff;
		int unsigned blk;
		int unsigned nblk;
		int unsigned run;
		int unsigned roll;
		int unsigned directed;
		logic        dec;
		logic        dlt;
		logic        noisy;
		logic        first;

		arst_n             = 1'b0;
		src_if.valid       = 1'b0;
		src_if.data_byte   = '0;
		src_if.block_start = 1'b0;
		cfg_if.valid       = 1'b0;
		cfg_if.reg_index   = bsd_pkg::CFG_CHANNEL_COUNT;
		cfg_if.wdata       = '0;
		dst_if.ready       = 1'b0;

		// settings after reset
		chan_cfg = bsd_pkg::ccnt_t'(1);
		elem_cfg = bsd_pkg::ecnt_t'(1);
		dec_mode = 1'b0;
		delta_on = 1'b1;
		clear_history();

		// Directed: one-byte blocks under the reset settings, each one a block end
		push_item(8'h00, 1'b1);
		push_item(8'hFF, 1'b0);
		push_item(8'h01, 1'b0);
		push_pause();

		// one full encode block, then a new block begun without a start flag
		push_settings(3, 2, 1'b0, 1'b1);
		push_item(8'h10, 1'b1);
		push_item(8'h20, 1'b0);
		push_item(8'h30, 1'b0);
		push_item(8'h05, 1'b0);
		push_item(8'hFF, 1'b0);
		push_item(8'h00, 1'b0);
		push_item(8'h7F, 1'b0);
		push_item(8'h80, 1'b0);

		// shrink and switch to decode mid-block: channel counter beyond its limit
		push_settings(2, 2, 1'b1, 1'b1);
		push_item(8'hFE, 1'b0);
		push_item(8'h03, 1'b0);
		push_item(8'hAA, 1'b0);
		push_item(8'h55, 1'b0);

		// zero sizes act as one; delta off passes the byte through
		push_settings(0, 0, 1'b0, 1'b0);
		push_item(8'h5A, 1'b0);
		push_item(8'hA5, 1'b1);

		// oversize sizes saturate
		push_settings(127, (1 << bsd_pkg::ECNT_W) - 1, 1'b0, 1'b1);
		push_item(8'hC3, 1'b1);
		push_item(8'h3C, 1'b0);
		push_item(8'h99, 1'b0);
		push_pause();
		directed = items_queued;

		// Random: a wide encode run first so the high address bits move
		push_settings(bsd_pkg::MAX_CHANNELS, bsd_pkg::MAX_ELEMS, 1'b0, 1'b1);
		for (int i = 0; i < 140; i++)
			push_item(bsd_pkg::byte_t'($urandom), i == 0);

		while (items_queued < directed + RANDOM_ITEMS) begin
			roll = $urandom_range(0, 9);
			if (roll == 0) begin
				case ($urandom_range(0, 2))
					0: c_raw = bsd_pkg::MAX_CHANNELS;
					1: c_raw = 127;
					default: c_raw = $urandom_range(9, 127);
				endcase
				case ($urandom_range(0, 2))
					0: e_raw = bsd_pkg::MAX_ELEMS;
					1: e_raw = (1 << bsd_pkg::ECNT_W) - 1;
					default: e_raw = $urandom_range(9, (1 << bsd_pkg::ECNT_W) - 1);
				endcase
			end else if (roll == 1) begin
				c_raw = $urandom_range(0, 3);
				e_raw = $urandom_range(0, 3);
			end else begin
				c_raw = $urandom_range(1, 8);
				e_raw = $urandom_range(1, 8);
			end
			c_eff = (c_raw == 0) ? 1 : ((c_raw > bsd_pkg::MAX_CHANNELS) ?
				bsd_pkg::MAX_CHANNELS : c_raw);
			e_eff = (e_raw == 0) ? 1 : ((e_raw > bsd_pkg::MAX_ELEMS) ?
				bsd_pkg::MAX_ELEMS : e_raw);
			blk   = c_eff * e_eff;
			dec   = ($urandom_range(0, 1) != 0);
			dlt   = ($urandom_range(0, 3) != 0);
			noisy = ($urandom_range(0, 4) == 0);
			push_settings(c_raw, e_raw, dec, dlt);

			if (blk > 64) begin
				// large block: a partial run, the next block restarts it
				run = $urandom_range(30, 150);
				for (int i = 0; i < run; i++)
					push_item(bsd_pkg::byte_t'($urandom),
						(i == 0) || (noisy && $urandom_range(0, 19) == 0));
			end else begin
				// whole blocks; the first may carry on from a block left open
				nblk = $urandom_range(1, 4);
				for (int b = 0; b < nblk; b++) begin
					for (int i = 0; i < blk; i++) begin
						first = 1'b0;
						if (i == 0)
							first = (b == 0) ? ($urandom_range(0, 3) != 0) :
								($urandom_range(0, 1) != 0);
						if (noisy && $urandom_range(0, 9) == 0)
							first = 1'b1;
						push_item(bsd_pkg::byte_t'($urandom), first);
					end
				end
				// sometimes leave a block open for the next settings
				if ($urandom_range(0, 3) == 0) begin
					run = $urandom_range(1, blk);
					for (int i = 0; i < run; i++)
						push_item(bsd_pkg::byte_t'($urandom), 1'b0);
				end
			end
			if ($urandom_range(0, 5) == 0)
				push_pause();
		end

		repeat (10) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (stream_ops.size() != 0 || src_if.valid || due_out.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("Covered %0d items and %0d results with %0d block ends, %0d register writes,",
			items_taken, results_seen, blocks_ended, reg_writes);
		$display("%0d drain pauses, encode and decode with delta on and off; %0d mismatches.",
			drain_pauses, mismatches);
		if (mismatches == 0)
			$display("byte_split_channel_delta_filter test passed");
		else
			$display("byte_split_channel_delta_filter test failed");
		$finish;
	end

endmodule

// ----- byte_split_channel_delta_filter.f -----
src/bsd_pkg.sv
src/bsd_ifs.sv
src/byte_split_channel_delta_filter.sv
dv/tb_byte_split_channel_delta_filter.sv
